>>> hdl/cbc_pkg.sv
`default_nettype none

package cbc_pkg;

    // Cartridge kinds
    localparam logic [2:0] KIND_ROM  = 3'd0;
    localparam logic [2:0] KIND_MBC1 = 3'd1;
    localparam logic [2:0] KIND_MBC2 = 3'd2;
    localparam logic [2:0] KIND_MBC3 = 3'd3;
    localparam logic [2:0] KIND_MBC5 = 3'd4;

    // Bus access codes
    localparam logic [1:0] OP_ROM_RD  = 2'd0;
    localparam logic [1:0] OP_ROM_WR  = 2'd1;
    localparam logic [1:0] OP_SRAM_RD = 2'd2;
    localparam logic [1:0] OP_SRAM_WR = 2'd3;

    // Configuration register indexes
    localparam logic CFG_CART_KIND  = 1'b0;
    localparam logic CFG_BANK_COUNT = 1'b1;

    // Field widths
    localparam int ADDR_W      = 15;
    localparam int DATA_W      = 8;
    localparam int ROM_ADDR_W  = 23;
    localparam int ROM_SEL_W   = 16;
    localparam int COUNT_W     = 10;
    localparam int KIND_W      = 3;
    localparam int SRAM_SEL_W  = 2;
    localparam int BANK_OFFS_W = 14;    // 16 KiB ROM banks

    // Control write regions, inclusive upper ends
    localparam logic [ADDR_W-1:0] REG_ENABLE_END   = 15'h1FFF;
    localparam logic [ADDR_W-1:0] REG_MBC5_LOW_END = 15'h2FFF;
    localparam logic [ADDR_W-1:0] REG_ROM_BANK_END = 15'h3FFF;
    localparam logic [ADDR_W-1:0] REG_UPPER_END    = 15'h5FFF;

    localparam logic [3:0]         RAM_ENABLE_KEY = 4'hA;
    localparam logic [COUNT_W-1:0] MBC5_WIDE_COUNT = 10'd256;
    localparam logic [DATA_W-1:0]  SRAM_OFF_BYTE  = 8'hFF;

    localparam logic [KIND_W-1:0]  KIND_RESET  = KIND_ROM;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd2;

    typedef struct packed {
        logic [ROM_SEL_W-1:0]  rom_sel;
        logic [SRAM_SEL_W-1:0] sram_sel;
        logic                  ram_en;
        logic                  sram_banking;
    } bank_state_t;

endpackage

`default_nettype wire

>>> hdl/cbc_bank_regs.sv
`default_nettype none

module cbc_bank_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [cbc_pkg::ADDR_W-1:0]   addr,
    input  wire logic [cbc_pkg::DATA_W-1:0]   wr_data,
    input  wire logic [cbc_pkg::KIND_W-1:0]   kind,
    input  wire logic [cbc_pkg::COUNT_W-1:0]  bank_count,
    output cbc_pkg::bank_state_t              bank_state
);
    import cbc_pkg::*;

    logic [ROM_SEL_W-1:0]  rom_sel_reg, rom_sel_next;
    logic [SRAM_SEL_W-1:0] sram_sel_reg, sram_sel_next;
    logic                  ram_en_reg, ram_en_next;
    logic                  sram_banking_reg, sram_banking_next;
    logic                  key_match;

    // Low bank bits with bank 0 remapped to 1
    function automatic logic [ROM_SEL_W-1:0] low_bank(
        input logic [ROM_SEL_W-1:0] cur,
        input logic [ROM_SEL_W-1:0] keep,
        input logic [DATA_W-1:0]    v
    );
        logic [DATA_W-1:0] vv;
        vv = (v == '0) ? DATA_W'(1) : v;
        return (cur & keep) | {{(ROM_SEL_W-DATA_W){1'b0}}, vv};
    endfunction

    assign key_match = (wr_data[3:0] == RAM_ENABLE_KEY);

    always_comb
    begin
        rom_sel_next      = rom_sel_reg;
        sram_sel_next     = sram_sel_reg;
        ram_en_next       = ram_en_reg;
        sram_banking_next = sram_banking_reg;
        if (wr_en)
        begin
            unique case (kind)
                KIND_MBC1:
                begin
                    if (addr <= REG_ENABLE_END)
                        ram_en_next = key_match;
                    else if (addr <= REG_ROM_BANK_END)
                        rom_sel_next = low_bank(rom_sel_reg, 16'h00E0,
                                                wr_data & 8'h1F);
                    else if (addr <= REG_UPPER_END)
                    begin
                        if (sram_banking_reg)
                            sram_sel_next = wr_data[1:0];
                        else
                            rom_sel_next = (rom_sel_reg & 16'h001F)
                                           | {9'd0, wr_data[1:0], 5'd0};
                    end
                    else if (wr_data[0])
                    begin
                        sram_banking_next = 1'b1;
                        rom_sel_next      = rom_sel_reg & 16'h001F;
                    end
                    else
                        sram_banking_next = 1'b0;
                end
                KIND_MBC2:
                begin
                    // address bit 8 picks enable vs bank on this kind
                    if (addr <= REG_ENABLE_END)
                    begin
                        if (!addr[8])
                            ram_en_next = key_match;
                    end
                    else if (addr <= REG_ROM_BANK_END)
                    begin
                        if (addr[8])
                            rom_sel_next = low_bank(rom_sel_reg, 16'h00E0,
                                                    wr_data & 8'h1F);
                    end
                end
                KIND_MBC3:
                begin
                    if (addr <= REG_ENABLE_END)
                        ram_en_next = key_match;
                    else if (addr <= REG_ROM_BANK_END)
                        rom_sel_next = low_bank(16'h0000, 16'h0000,
                                                wr_data & 8'h7F);
                end
                KIND_MBC5:
                begin
                    if (addr <= REG_ENABLE_END)
                        ram_en_next = key_match;
                    else if (addr <= REG_MBC5_LOW_END)
                        rom_sel_next = low_bank(rom_sel_reg, 16'hFF00, wr_data);
                    else if (addr <= REG_ROM_BANK_END)
                    begin
                        // high byte only exists on large carts
                        if (bank_count < MBC5_WIDE_COUNT)
                            rom_sel_next = low_bank(rom_sel_reg, 16'hFF00, wr_data);
                        else
                            rom_sel_next = {wr_data, rom_sel_reg[7:0]};
                    end
                    else
                        sram_sel_next = wr_data[1:0];
                end
                default:
                begin
                    // plain ROM and unused kinds ignore writes
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_sel_reg      <= '0;
            sram_sel_reg     <= '0;
            ram_en_reg       <= 1'b0;
            sram_banking_reg <= 1'b0;
        end
        else
        begin
            rom_sel_reg      <= rom_sel_next;
            sram_sel_reg     <= sram_sel_next;
            ram_en_reg       <= ram_en_next;
            sram_banking_reg <= sram_banking_next;
        end
    end

    assign bank_state.rom_sel      = rom_sel_reg;
    assign bank_state.sram_sel     = sram_sel_reg;
    assign bank_state.ram_en       = ram_en_reg;
    assign bank_state.sram_banking = sram_banking_reg;

endmodule

`default_nettype wire

>>> hdl/cbc_rem_div.sv
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module cbc_rem_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [cbc_pkg::ROM_SEL_W-1:0] dividend,
    input  wire logic [cbc_pkg::COUNT_W-1:0]   divisor,
    output logic                               done,
    output logic [cbc_pkg::COUNT_W-1:0]        remainder
);
    import cbc_pkg::*;

    localparam int CNT_W = $clog2(ROM_SEL_W);

    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [ROM_SEL_W-1:0] dvd_reg, dvd_next;
    logic [COUNT_W-1:0]   d_reg, d_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [COUNT_W:0]     trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[ROM_SEL_W-1]};
    assign fits  = (trial >= {1'b0, d_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            d_next   = (divisor == '0) ? COUNT_W'(1) : divisor;   // zero count acts as one
            cnt_next = CNT_W'(ROM_SEL_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? COUNT_W'(trial - {1'b0, d_reg}) : trial[COUNT_W-1:0];
            dvd_next = {dvd_reg[ROM_SEL_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        d_reg   <= d_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (rem_reg < d_reg))
        else $error("partial remainder not below divisor");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> run_reg && (cnt_reg == CNT_W'(ROM_SEL_W - 1)))
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg && $past(run_reg))
        else $error("done without a finished run");

endmodule

`default_nettype wire

>>> hdl/cartridge_bank_controller_unit.sv
// Cartridge bank controller: MBC1/2/3/5 or plain ROM, picked by cart_kind.
// Input stream s_*: one bus access per word. Output stream m_*: one result
// word per access (physical ROM address for ROM reads, SRAM byte for SRAM
// reads, zeros otherwise). Config port: cfg_wr_en / cfg_index / cfg_data,
// index 0 = cart kind, 1 = ROM bank count; write only while idle.
// Path from accept to m_tvalid:
//   ROM read of bank 0, control write: registered the cycle after accept
//   SRAM write: via ST_SRAM_ACC
//   SRAM read: via ST_SRAM_ACC, ST_SRAM_DATA (sync SRAM read + reg)
//   ROM read above bank 0: via ST_DIV until the divider is done
// The switchable bank is the bank register mod the bank count; the remainder
// comes from a bit-serial divider (16 steps + done flag), the worst case.
// One access is in flight at a time; s_tready is back the cycle the result
// is registered, so short accesses run one word per cycle while m_tready is high.
// m_* is a registered output: if the receiver stalls, the result holds and
// s_tready stays low until that word is taken.
// Reset clears kind to plain ROM, bank count to 2, bank/enable/mode state
// to zero. SRAM content is not cleared; reads before writes are undefined.
`default_nettype none

module cartridge_bank_controller_unit #(
    parameter int SRAM_BANK_BYTES = 8192,
    parameter int SRAM_BANKS      = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // opcode[1:0], address[16:2], data[24:17]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // rom_address[22:0], sram_data[30:23]
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [9:0]  cfg_data
);
    import cbc_pkg::*;

    localparam int MEM_DEPTH = SRAM_BANKS * SRAM_BANK_BYTES;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int OFFS_W    = $clog2(SRAM_BANK_BYTES);
    localparam int SBANK_W   = (SRAM_BANKS > 1) ? $clog2(SRAM_BANKS) : 1;
    localparam int QSTEPS    = $clog2((1 << ADDR_W) / SRAM_BANK_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_DIV       = 4'b0010,
        ST_SRAM_ACC  = 4'b0100,
        ST_SRAM_DATA = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [KIND_W-1:0]  kind_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [1:0]        in_op;
    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_data;
    logic              accept;

    logic [1:0]         op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [OFFS_W-1:0]  offs_reg, offs_next;
    logic [SBANK_W-1:0] sbank_reg, sbank_next;

    logic                  out_vld_reg, out_vld_next;
    logic [ROM_ADDR_W-1:0] out_rom_reg, out_rom_next;
    logic [DATA_W-1:0]     out_sram_reg, out_sram_next;
    logic                  out_load;

    bank_state_t        bank;
    logic               ctl_wr;
    logic               div_start;
    logic               div_done;
    logic [COUNT_W-1:0] div_rem;

    logic [IDX_W-1:0]  mem_idx;
    logic              mem_we;
    logic              mem_re;
    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] mem_q_reg;

    assign in_op   = s_tdata[1:0];
    assign in_addr = s_tdata[16:2];
    assign in_data = s_tdata[24:17];

    assign s_tready = (state_reg == ST_IDLE) && (!out_vld_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign ctl_wr    = accept && (in_op == OP_ROM_WR);
    assign div_start = accept && (in_op == OP_ROM_RD) && in_addr[BANK_OFFS_W];

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CART_KIND:  kind_reg  <= cfg_data[KIND_W-1:0];
                CFG_BANK_COUNT: count_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    cbc_bank_regs u_bank_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (ctl_wr),
        .addr       (in_addr),
        .wr_data    (in_data),
        .kind       (kind_reg),
        .bank_count (count_reg),
        .bank_state (bank)
    );

    cbc_rem_div u_rem_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (bank.rom_sel),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // SRAM offset wraps per bank; quotient is small, so a few trial subtracts
    always_comb
    begin
        logic [ADDR_W:0] r;
        r = {1'b0, in_addr};
        for (int j = QSTEPS - 1; j >= 0; j--)
        begin
            if (r >= (ADDR_W+1)'(SRAM_BANK_BYTES << j))
                r = r - (ADDR_W+1)'(SRAM_BANK_BYTES << j);
        end
        offs_next = r[OFFS_W-1:0];
    end

    // SRAM bank: MBC1 in ROM-banking mode uses bank 0; then wrap to SRAM_BANKS
    always_comb
    begin
        logic [2:0] b;
        b = (kind_reg == KIND_MBC1 && !bank.sram_banking) ? 3'd0 : {1'b0, bank.sram_sel};
        for (int j = 0; j < 3; j++)
        begin
            if (b >= 3'(SRAM_BANKS))
                b = b - 3'(SRAM_BANKS);
        end
        sbank_next = SBANK_W'(b);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= in_op;
            addr_reg  <= in_addr;
            data_reg  <= in_data;
            offs_reg  <= offs_next;
            sbank_reg <= sbank_next;
        end
    end

    assign mem_idx = IDX_W'(int'(sbank_reg) * SRAM_BANK_BYTES + int'(offs_reg));
    assign mem_we  = (state_reg == ST_SRAM_ACC) && (op_reg == OP_SRAM_WR) && bank.ram_en;
    assign mem_re  = (state_reg == ST_SRAM_ACC) && (op_reg == OP_SRAM_RD);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_idx] <= data_reg;
        if (mem_re)
            mem_q_reg <= mem[mem_idx];
    end

    // sequencer and result register
    always_comb
    begin
        state_next    = state_reg;
        out_load      = 1'b0;
        out_rom_next  = '0;
        out_sram_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_ROM_RD:
                        begin
                            if (in_addr[BANK_OFFS_W])
                                state_next = ST_DIV;
                            else
                            begin
                                out_load     = 1'b1;
                                out_rom_next = ROM_ADDR_W'(in_addr);
                            end
                        end
                        OP_ROM_WR:
                            out_load = 1'b1;
                        OP_SRAM_RD, OP_SRAM_WR:
                            state_next = ST_SRAM_ACC;
                        default: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    out_load     = 1'b1;
                    out_rom_next = {div_rem[ROM_ADDR_W-BANK_OFFS_W-1:0],
                                    addr_reg[BANK_OFFS_W-1:0]};
                    state_next   = ST_IDLE;
                end
            end
            ST_SRAM_ACC:
            begin
                if (op_reg == OP_SRAM_WR)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_SRAM_DATA;
            end
            ST_SRAM_DATA:
            begin
                out_load      = 1'b1;
                out_sram_next = bank.ram_en ? mem_q_reg : SRAM_OFF_BYTE;
                state_next    = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rom_reg  <= out_rom_next;
            out_sram_reg <= out_sram_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_sram_reg, out_rom_reg};

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside bank lookup");

    a_one_field_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_rom_reg == '0) || (out_sram_reg == '0))
        else $error("result carries both ROM address and SRAM byte");

    a_sram_data_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRAM_DATA) |-> ($past(state_reg) == ST_SRAM_ACC)
                                        && (op_reg == OP_SRAM_RD))
        else $error("SRAM data stage without a read access");

    a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && state_reg != ST_IDLE) |-> !out_vld_reg)
        else $error("result overwrites a pending word");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

// Stream testbench for the cartridge bank controller.
// An initial block builds bus accesses, runs them through a local copy of the
// bank logic as they are queued, and stores each access together with the
// result word it must produce. A clocked driver feeds the accesses to s_*, a
// clocked monitor takes result words from m_* and compares them in order.
module testbench;
    import cbc_pkg::*;

    localparam int SRAM_BANK_BYTES = 8192;
    localparam int SRAM_BANKS      = 4;
    localparam int BANK_BYTES      = 16384;
    localparam int SRAM_BYTES      = SRAM_BANK_BYTES * SRAM_BANKS;

    // Kinds the block treats like plain ROM
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 105;
    localparam int DRAIN_CYCLES    = 20;     // longer than the slowest access
    localparam int IDLE_LIMIT      = 2000;   // cycles with no handshake at all
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } bus_access_t;

    typedef struct packed {
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [DATA_W-1:0]     sram_data;
    } access_result_t;

    typedef struct packed {
        bus_access_t    acc;
        access_result_t res;
    } queued_word_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_CART_KIND;
    logic [9:0]  cfg_data  = '0;

    cartridge_bank_controller_unit #(
        .SRAM_BANK_BYTES(SRAM_BANK_BYTES),
        .SRAM_BANKS     (SRAM_BANKS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // opcode[1:0], address[16:2], data[24:17]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // rom_address[22:0], sram_data[30:23]
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------------
    // Local copy of the controller state, advanced as accesses are queued.
    // Queue order equals issue order, and config only changes while idle,
    // so predicting at queue time gives the same answers as at accept time.
    // ---------------------------------------------------------------------
    logic [KIND_W-1:0]     kind_m;
    logic [COUNT_W-1:0]    count_m;
    logic [ROM_SEL_W-1:0]  rom_sel_m;
    logic [SRAM_SEL_W-1:0] sram_sel_m;
    logic                  ram_en_m;
    logic                  sram_banking_m;
    logic [7:0]            sram_m    [0:SRAM_BYTES-1];
    bit                    written_m [0:SRAM_BYTES-1];

    queued_word_t   access_queue[$];       // accesses not yet sent
    access_result_t predicted_results[$];  // results of accepted accesses
    logic [ADDR_W-1:0] recent_sram_addr[$]; // SRAM offsets written lately

    bit no_gaps = 1'b0;
    int mismatch_count = 0;
    int rom_reads = 0, ctrl_writes = 0, sram_reads = 0, sram_writes = 0;
    int settings_run = 0;

    // SRAM byte picked by an offset. MBC1 in ROM-banking mode is held to bank 0.
    function automatic int sram_slot(input logic [ADDR_W-1:0] addr);
        int bank;
        bank = (kind_m == KIND_MBC1 && !sram_banking_m) ? 0 : int'(sram_sel_m);
        return (bank % SRAM_BANKS) * SRAM_BANK_BYTES + int'(addr) % SRAM_BANK_BYTES;
    endfunction

    // Low bank write: a zero bank number is bumped to 1.
    function automatic logic [ROM_SEL_W-1:0] bank_low(input logic [15:0] keep,
                                                     input logic [7:0] v);
        return (rom_sel_m & keep) | ((v == 8'd0) ? 16'd1 : {8'd0, v});
    endfunction

    function automatic void control_write(input logic [ADDR_W-1:0] a, input logic [7:0] v);
        logic enable;
        logic [6:0] b7;
        enable = (v[3:0] == RAM_ENABLE_KEY);
        case (kind_m)
            KIND_MBC1:
            begin
                if (a <= REG_ENABLE_END)
                    ram_en_m = enable;
                else if (a <= REG_ROM_BANK_END)
                    rom_sel_m = bank_low(16'h00E0, {3'd0, v[4:0]});
                else if (a <= REG_UPPER_END)
                begin
                    if (sram_banking_m)
                        sram_sel_m = v[1:0];
                    else
                        rom_sel_m = (rom_sel_m & 16'h001F) | {9'd0, v[1:0], 5'd0};
                end
                else if (v[0])
                begin
                    sram_banking_m = 1'b1;
                    rom_sel_m = rom_sel_m & 16'h001F;
                end
                else
                    sram_banking_m = 1'b0;
            end
            KIND_MBC2:
            begin
                // address bit 8 steers between enable and bank
                if (a <= REG_ENABLE_END)
                begin
                    if (!a[8])
                        ram_en_m = enable;
                end
                else if (a <= REG_ROM_BANK_END)
                begin
                    if (a[8])
                        rom_sel_m = bank_low(16'h00E0, {3'd0, v[4:0]});
                end
            end
            KIND_MBC3:
            begin
                // upper regions are ignored
                if (a <= REG_ENABLE_END)
                    ram_en_m = enable;
                else if (a <= REG_ROM_BANK_END)
                begin
                    b7 = v[6:0];
                    rom_sel_m = (b7 == 7'd0) ? 16'd1 : {9'd0, b7};
                end
            end
            KIND_MBC5:
            begin
                if (a <= REG_ENABLE_END)
                    ram_en_m = enable;
                else if (a <= REG_MBC5_LOW_END)
                    rom_sel_m = bank_low(16'hFF00, v);
                else if (a <= REG_ROM_BANK_END)
                begin
                    // high byte only once the cart has 256 banks or more
                    if (count_m < MBC5_WIDE_COUNT)
                        rom_sel_m = bank_low(16'hFF00, v);
                    else
                        rom_sel_m = (rom_sel_m & 16'h00FF) | {v, 8'd0};
                end
                else
                    sram_sel_m = v[1:0];
            end
            default: ;   // plain ROM and spare kinds drop control writes
        endcase
    endfunction

    function automatic access_result_t predict_access(input bus_access_t acc);
        access_result_t res;
        int unsigned cnt, bank;
        logic [31:0] phys;
        int slot;
        res = '0;
        case (acc.op)
            OP_ROM_RD:
            begin
                if (!acc.addr[14])
                    res.rom_address = {8'd0, acc.addr};
                else
                begin
                    cnt  = (count_m == '0) ? 1 : int'(count_m);
                    bank = int'(rom_sel_m) % cnt;
                    phys = bank * BANK_BYTES + int'(acc.addr[13:0]);
                    res.rom_address = phys[ROM_ADDR_W-1:0];   // wraps past 8 MiB
                end
            end
            OP_ROM_WR:
                control_write(acc.addr, acc.data);
            OP_SRAM_RD:
                res.sram_data = ram_en_m ? sram_m[sram_slot(acc.addr)] : SRAM_OFF_BYTE;
            default:
            begin
                if (ram_en_m)
                begin
                    slot = sram_slot(acc.addr);
                    sram_m[slot]    = acc.data;
                    written_m[slot] = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    // Predict an access and queue it for the driver. A read of a byte that
    // was never written (with RAM on) is turned into a write of that byte.
    task automatic queue_access(input bus_access_t acc);
        queued_word_t w;
        if (acc.op == OP_SRAM_RD && ram_en_m && !written_m[sram_slot(acc.addr)])
            acc.op = OP_SRAM_WR;
        case (acc.op)
            OP_ROM_RD:  rom_reads++;
            OP_ROM_WR:  ctrl_writes++;
            OP_SRAM_RD: sram_reads++;
            default:
            begin
                sram_writes++;
                recent_sram_addr.push_back(acc.addr);
                if (recent_sram_addr.size() > 16)
                    void'(recent_sram_addr.pop_front());
            end
        endcase
        w.acc = acc;
        w.res = predict_access(acc);
        access_queue.push_back(w);
    endtask

    task automatic put(input logic [1:0] op, input logic [14:0] addr, input logic [7:0] data);
        bus_access_t acc;
        acc.op   = op;
        acc.addr = addr;
        acc.data = data;
        queue_access(acc);
    endtask

    // Wait until every queued word is sent and answered, then let the
    // pipeline settle before touching the config port.
    task automatic wait_drained();
        @(negedge clk);
        while (access_queue.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_CART_KIND)
            kind_m = value[KIND_W-1:0];
        else
            count_m = value;
    endtask

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input access_result_t exp_r,
                                   input access_result_t act_r);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH %s at %0t: expected rom_address %h sram_data %h, got %h %h",
                     what, $realtime, exp_r.rom_address, exp_r.sram_data,
                     act_r.rom_address, act_r.sram_data);
    endtask

    // ---------------------------------------------------------------------
    // Driver: one access word per handshake. valid stays up between words
    // when no gap is drawn, so it is never dropped and raised in one step.
    // ---------------------------------------------------------------------
    int             send_gap = 0;
    access_result_t sent_result;

    always @(posedge clk)
    begin
        queued_word_t w;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_results.push_back(sent_result);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (access_queue.size() != 0)
                begin
                    w = access_queue.pop_front();
                    sent_result = w.res;
                    s_tdata  <= {7'd0, w.acc.data, w.acc.addr, w.acc.op};
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random back-pressure, in-order compare of every result word.
    // ---------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        access_result_t got, want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.rom_address = m_tdata[22:0];
                got.sram_data   = m_tdata[30:23];
                if (predicted_results.size() == 0)
                    report_mismatch("word with nothing expected", '0, got);
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.rom_address !== want.rom_address
                        || got.sram_data !== want.sram_data)
                        report_mismatch("result word", want, got);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Watchdog: any handshake or config write restarts the count.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    logic [2:0] phase_kind  [RANDOM_PHASES] = '{KIND_MBC1, KIND_MBC2, KIND_MBC3, KIND_MBC5,
                                                KIND_MBC5, KIND_MBC1, KIND_MBC3, KIND_MBC2,
                                                KIND_SPARE_6, KIND_MBC5, KIND_MBC1, KIND_ROM};
    logic [9:0] phase_count [RANDOM_PHASES] = '{10'd64, 10'd16, 10'd128, 10'd512,
                                                10'd255, 10'd1023, 10'd256, 10'd1,
                                                10'd700, 10'd256, 10'd2, 10'd0};
    logic [14:0] region_edges [9] = '{15'h1FFF, 15'h2000, 15'h2FFF, 15'h3000, 15'h3FFF,
                                      15'h4000, 15'h5FFF, 15'h6000, 15'h7FFF};

    initial
    begin
        bus_access_t acc;
        int r;
        // state after reset
        kind_m         = KIND_RESET;
        count_m        = COUNT_RESET;
        rom_sel_m      = '0;
        sram_sel_m     = '0;
        ram_en_m       = 1'b0;
        sram_banking_m = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings, plain ROM: writes do nothing, RAM reads give 0xFF.
        put(OP_ROM_RD, 15'h0000, 8'h00);
        put(OP_ROM_RD, 15'h7FFF, 8'hFF);
        put(OP_ROM_RD, 15'h4000, 8'h00);
        put(OP_ROM_WR, 15'h0000, 8'h0A);
        put(OP_SRAM_RD, 15'h7FFF, 8'h00);
        put(OP_SRAM_WR, 15'h1234, 8'h55);

        // MBC1 with a zero bank count (counts as one bank); bank 0 bumped to 1;
        // offset wrap in SRAM; RAM banking mode selects bank 3.
        wait_drained();
        write_reg(CFG_CART_KIND, {7'd0, KIND_MBC1});
        write_reg(CFG_BANK_COUNT, 10'd0);
        put(OP_ROM_WR, 15'h1FFF, 8'h0A);
        put(OP_ROM_WR, 15'h2000, 8'h00);
        put(OP_ROM_RD, 15'h4000, 8'h00);
        put(OP_SRAM_WR, 15'h7FFF, 8'hFF);
        put(OP_SRAM_RD, 15'h7FFF, 8'h00);
        put(OP_ROM_WR, 15'h6000, 8'h01);
        put(OP_ROM_WR, 15'h5FFF, 8'h03);
        put(OP_SRAM_WR, 15'h0000, 8'h00);
        put(OP_SRAM_RD, 15'h0000, 8'h00);
        put(OP_ROM_WR, 15'h7FFF, 8'h00);

        // MBC5 with the largest count: high bank byte, physical address wrap.
        wait_drained();
        write_reg(CFG_CART_KIND, {7'd0, KIND_MBC5});
        write_reg(CFG_BANK_COUNT, 10'd1023);
        put(OP_ROM_WR, 15'h0000, 8'h0A);
        put(OP_ROM_WR, 15'h2FFF, 8'hFF);
        put(OP_ROM_WR, 15'h3000, 8'h02);
        put(OP_ROM_RD, 15'h7FFF, 8'h00);
        put(OP_ROM_WR, 15'h4000, 8'hFF);
        put(OP_SRAM_RD, 15'h2000, 8'h00);

        // Spare kind keeps the old state and ignores control writes.
        wait_drained();
        write_reg(CFG_CART_KIND, {7'd0, KIND_SPARE_7});
        put(OP_ROM_WR, 15'h0000, 8'h00);
        put(OP_SRAM_RD, 15'h2000, 8'h00);
        settings_run = 4;

        // Random phases, one controller setting each. Control writes aim at
        // the regions and their edges; SRAM traffic reuses recent offsets so
        // reads land on written bytes.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            write_reg(CFG_CART_KIND, {7'd0, phase_kind[p]});
            write_reg(CFG_BANK_COUNT, phase_count[p]);
            no_gaps = (p % 4 == 3);
            settings_run++;
            repeat (WORDS_PER_PHASE)
            begin
                acc.addr = 15'($urandom);
                acc.data = 8'($urandom);
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    acc.op = OP_ROM_RD;
                    if ($urandom_range(0, 9) < 7)
                        acc.addr[14] = 1'b1;
                end
                else if (r < 60)
                begin
                    acc.op = OP_ROM_WR;
                    case ($urandom_range(0, 4))
                        0:       acc.addr = 15'($urandom_range(16'h0000, 16'h1FFF));
                        1:       acc.addr = 15'($urandom_range(16'h2000, 16'h2FFF));
                        2:       acc.addr = 15'($urandom_range(16'h3000, 16'h3FFF));
                        3:       acc.addr = 15'($urandom_range(16'h4000, 16'h5FFF));
                        default: acc.addr = 15'($urandom_range(16'h6000, 16'h7FFF));
                    endcase
                    if ($urandom_range(0, 99) < 15)
                        acc.addr = region_edges[$urandom_range(0, 8)];
                    // keep RAM switched on most of the time
                    if (acc.addr <= REG_ENABLE_END && $urandom_range(0, 3) != 0)
                        acc.data[3:0] = RAM_ENABLE_KEY;
                end
                else if (r < 80)
                begin
                    acc.op = OP_SRAM_WR;
                    if (recent_sram_addr.size() != 0 && $urandom_range(0, 1) == 0)
                        acc.addr = recent_sram_addr[$urandom_range(0, recent_sram_addr.size() - 1)];
                end
                else
                begin
                    acc.op = OP_SRAM_RD;
                    if (recent_sram_addr.size() != 0 && $urandom_range(0, 9) < 7)
                        acc.addr = recent_sram_addr[$urandom_range(0, recent_sram_addr.size() - 1)];
                end
                queue_access(acc);
            end
        end

        wait_drained();
        $display("ran %0d controller settings: %0d ROM reads, %0d control writes,",
                 settings_run, rom_reads, ctrl_writes);
        $display("%0d SRAM reads, %0d SRAM writes, %0d mismatches",
                 sram_reads, sram_writes, mismatch_count);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> cartridge_bank_controller_unit.f
hdl/cbc_pkg.sv
hdl/cbc_bank_regs.sv
hdl/cbc_rem_div.sv
hdl/cartridge_bank_controller_unit.sv
tb/testbench.sv
